// ===== rtl/jbt_pkg.sv =====
// Shared types, token codes and keyword tables for the JSON byte tokenizer.
package jbt_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_SIGN, M_INT, M_DOT, M_FRAC, M_E, M_ESIGN, M_EXP, M_LIT
  } lex_mode_t;

  typedef enum logic [2:0] {
    ST_WAIT, ST_SCAN, ST_HELD, ST_CLOSE, ST_FHELD, ST_END, ST_FLUSH
  } ctl_state_t;

  localparam logic [3:0] K_UNDEF  = 4'd0;
  localparam logic [3:0] K_LBRACE = 4'd1;
  localparam logic [3:0] K_RBRACE = 4'd2;
  localparam logic [3:0] K_LBRACK = 4'd3;
  localparam logic [3:0] K_RBRACK = 4'd4;
  localparam logic [3:0] K_COLON  = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_STRING = 4'd7;
  localparam logic [3:0] K_NUMBER = 4'd8;
  localparam logic [3:0] K_TRUE   = 4'd9;
  localparam logic [3:0] K_END    = 4'd12;

  typedef struct packed {
    logic load;
    logic scan;
    logic held;
    logic close;
    logic end_tok;
    logic flush;
  } jbt_cmd_t;

  typedef struct packed {
    logic can_push;
    logic redo;
    logic lit_miss;
    logic held_last;
    logic is_lit;
    logic fin;
    logic hold_valid;
  } jbt_stat_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        ok;
    logic [31:0] start;
    logic [31:0] len;
    logic        neg;
    logic [63:0] mant;
    logic [15:0] power;
    logic        last;
  } tok_t;

  function automatic logic [2:0] word_len(input logic [1:0] w);
    word_len = (w == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] i);
    logic [39:0] s;
    unique case (w)
      2'd0:    s = {"true", 8'h00};
      2'd1:    s = "false";
      default: s = {"null", 8'h00};
    endcase
    unique case (i)
      3'd0:    word_char = s[39:32];
      3'd1:    word_char = s[31:24];
      3'd2:    word_char = s[23:16];
      3'd3:    word_char = s[15:8];
      3'd4:    word_char = s[7:0];
      default: word_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/json_byte_tokenizer.sv =====
// Top level of the JSON byte tokenizer: controller, datapath and checks.
// The tokenizer takes one byte of JSON text per input transaction and gives
// the tokens it completes, one per output transaction, with last_of_run set
// on the final token of each byte. Without output stalls a byte is accepted,
// scanned and flushed. A keyword that fails to match first gives out each
// held letter and then rescans the byte, and a number that a byte ends,
// unless it is a lone minus sign, has that byte rescanned. The last byte
// then closes the open token, gives out the held letters of an unfinished
// keyword and the end token, after which offsets restart at zero. An output
// stall holds each step. The scan state machine sets this sequence.
module json_byte_tokenizer import jbt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int EXP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic        token_ok,
  output logic [31:0] start_offset,
  output logic [31:0] text_length,
  output logic        is_negative,
  output logic [63:0] mantissa,
  output logic signed [15:0] power_of_ten,
  output logic        last_of_run
);

  jbt_cmd_t cmd;
  jbt_stat_t stat;
  tok_t tok;

  jbt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  jbt_datapath #(.OFFSET_BITS(OFFSET_BITS), .EXP_BITS(EXP_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .text_byte(text_byte),
    .is_final(is_final), .out_ready(out_ready), .out_valid(out_valid),
    .out_tok(tok)
  );

  assign token_kind = tok.kind;
  assign token_ok = tok.ok;
  assign start_offset = tok.start;
  assign text_length = tok.len;
  assign is_negative = tok.neg;
  assign mantissa = tok.mant;
  assign power_of_ten = $signed(tok.power);
  assign last_of_run = tok.last;

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.hold_valid)
    else $error("hold register not empty while waiting for a byte");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_END |-> last_of_run)
    else $error("end token not marked last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= K_END)
    else $error("token kind out of range");

endmodule

// ===== rtl/jbt_ctrl.sv =====
// Sequencing state machine of the tokenizer: one byte is scanned per pass.
module jbt_ctrl import jbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  jbt_stat_t stat,
  output jbt_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WAIT: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.can_push) begin
          priority if (stat.lit_miss) state_next = ST_HELD;
          else if (stat.redo) state_next = ST_SCAN;
          else if (stat.fin) state_next = ST_CLOSE;
          else state_next = ST_FLUSH;
        end
      end
      ST_HELD: begin
        if (stat.can_push && stat.held_last) state_next = ST_SCAN;
      end
      ST_CLOSE: begin
        if (stat.can_push) state_next = stat.is_lit ? ST_FHELD : ST_END;
      end
      ST_FHELD: begin
        if (stat.can_push && stat.held_last) state_next = ST_END;
      end
      ST_END: begin
        if (stat.can_push) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (stat.can_push) state_next = ST_WAIT;
      end
      default: state_next = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_WAIT: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:  cmd.scan = stat.can_push;
      ST_HELD:  cmd.held = stat.can_push;
      ST_CLOSE: cmd.close = stat.can_push && !stat.is_lit;
      ST_FHELD: cmd.held = stat.can_push;
      ST_END:   cmd.end_tok = stat.can_push;
      ST_FLUSH: cmd.flush = stat.can_push;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/jbt_datapath.sv =====
// Lexer state, number accumulators and the token hold and output registers.
module jbt_datapath import jbt_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter int EXP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  jbt_cmd_t    cmd,
  output jbt_stat_t   stat,
  input  logic [7:0]  text_byte,
  input  logic        is_final,
  input  logic        out_ready,
  output logic        out_valid,
  output tok_t        out_tok
);

  localparam logic [OFFSET_BITS-1:0] ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  localparam logic [EXP_BITS-1:0] FLO = {1'b1, {(EXP_BITS-1){1'b0}}};
  localparam logic [EXP_BITS-1:0] CAP = {EXP_BITS{1'b1}};
  localparam logic [EXP_BITS+1:0] PLO = {3'b111, {(EXP_BITS-1){1'b0}}};
  localparam logic [EXP_BITS+1:0] PHI = {3'b000, {(EXP_BITS-1){1'b1}}};

  lex_mode_t mode, mode_next;
  logic [63:0] mant, mant_next;
  logic [EXP_BITS-1:0] frac, frac_next, expd, expd_next;
  logic eneg, eneg_next, nneg, nneg_next;
  logic [OFFSET_BITS-1:0] pos, pos_next, tbeg, tbeg_next;
  logic [7:0] prev, prev_next, b, b_next;
  logic fin, fin_next;
  logic [2:0] midx, midx_next, hidx, hidx_next;
  logic [1:0] mword, mword_next;

  tok_t hold;
  logic hold_v;

  logic emit, e_ok, e_num, redo, lit_miss, held_last;
  logic [3:0] e_kind;
  logic [OFFSET_BITS-1:0] e_start, e_len, nxt;
  logic [3:0] dig;
  logic is_dig, is_sp;
  logic [63:0] mant10;
  logic [EXP_BITS+3:0] ed10;
  logic [2:0] wlen;
  logic signed [EXP_BITS+1:0] psum;
  logic [EXP_BITS-1:0] psat;
  logic [EXP_BITS+15:0] pext;
  logic [OFFSET_BITS+31:0] start_ext, len_ext;
  tok_t new_tok;
  logic can_push;

  assign nxt = pos + ONE;
  assign dig = b[3:0];
  assign is_dig = (b >= "0") && (b <= "9");
  assign is_sp = (b == " ") || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d) ||
                 (b == 8'h0b) || (b == 8'h0c);
  assign mant10 = (mant << 3) + (mant << 1) + {60'd0, dig};
  assign ed10 = ({4'd0, expd} << 3) + ({4'd0, expd} << 1) + {{EXP_BITS{1'b0}}, dig};
  assign wlen = word_len(mword);
  assign held_last = (hidx + 3'd1) >= midx;

  // Exponent is the signed exponent digits minus the count of fraction digits, saturated.
  assign psum = $signed({{2{frac[EXP_BITS-1]}}, frac}) +
                (eneg ? -$signed({2'b00, expd}) : $signed({2'b00, expd}));
  always_comb begin
    priority if (psum < $signed(PLO)) psat = PLO[EXP_BITS-1:0];
    else if (psum > $signed(PHI)) psat = PHI[EXP_BITS-1:0];
    else psat = psum[EXP_BITS-1:0];
  end
  assign pext = {{16{psat[EXP_BITS-1]}}, psat};

  always_comb begin
    mode_next = mode; mant_next = mant; frac_next = frac; expd_next = expd;
    eneg_next = eneg; nneg_next = nneg; pos_next = pos; tbeg_next = tbeg;
    prev_next = prev; b_next = b; fin_next = fin; midx_next = midx;
    hidx_next = hidx; mword_next = mword;
    emit = 1'b0; e_kind = K_UNDEF; e_ok = 1'b0; e_start = pos; e_len = ONE;
    e_num = 1'b0; redo = 1'b0; lit_miss = 1'b0;

    if (cmd.load) begin
      b_next = text_byte;
      fin_next = is_final;
    end

    if (cmd.scan) begin
      unique case (mode)
        M_STR: begin
          if (b == "\"" && prev != "\\") begin
            emit = 1'b1; e_kind = K_STRING; e_ok = 1'b1;
            e_start = tbeg; e_len = pos - tbeg; mode_next = M_IDLE;
          end
        end
        M_SIGN: begin
          if (is_dig) begin
            mant_next = mant10; mode_next = M_INT;
          end else begin
            emit = 1'b1; e_kind = K_NUMBER; e_num = 1'b1;
            e_start = tbeg; e_len = nxt - tbeg; mode_next = M_IDLE;
          end
        end
        M_INT, M_DOT, M_FRAC: begin
          priority if (is_dig) begin
            mant_next = mant10;
            if (mode != M_INT) begin
              if (frac != FLO) frac_next = frac - 1'b1;
              mode_next = M_FRAC;
            end
          end else if (b == "." && mode == M_INT) begin
            mode_next = M_DOT;
          end else if (b == "e" || b == "E") begin
            mode_next = M_E;
          end else begin
            emit = 1'b1; e_kind = K_NUMBER; e_num = 1'b1; e_ok = (mode != M_DOT);
            e_start = tbeg; e_len = pos - tbeg; mode_next = M_IDLE; redo = 1'b1;
          end
        end
        M_E, M_ESIGN, M_EXP: begin
          priority if (is_dig) begin
            expd_next = (ed10 > {4'd0, CAP}) ? CAP : ed10[EXP_BITS-1:0];
            mode_next = M_EXP;
          end else if (mode == M_E && (b == "-" || b == "+")) begin
            eneg_next = (b == "-");
            mode_next = M_ESIGN;
          end else begin
            emit = 1'b1; e_kind = K_NUMBER; e_num = 1'b1; e_ok = (mode == M_EXP);
            e_start = tbeg; e_len = pos - tbeg; mode_next = M_IDLE; redo = 1'b1;
          end
        end
        M_LIT: begin
          if (midx < wlen && b == word_char(mword, midx)) begin
            midx_next = midx + 3'd1;
            if (midx + 3'd1 == wlen) begin
              emit = 1'b1; e_kind = K_TRUE + {2'b00, mword}; e_ok = 1'b1;
              e_start = tbeg; e_len = {{(OFFSET_BITS-3){1'b0}}, wlen};
              mode_next = M_IDLE;
            end
          end else begin
            lit_miss = 1'b1;
            hidx_next = 3'd0;
          end
        end
        default: begin
          if (!is_sp) begin
            priority if (b == "{" || b == "}" || b == "[" || b == "]" ||
                         b == ":" || b == ",") begin
              emit = 1'b1; e_ok = 1'b1;
              priority if (b == "{") e_kind = K_LBRACE;
              else if (b == "}") e_kind = K_RBRACE;
              else if (b == "[") e_kind = K_LBRACK;
              else if (b == "]") e_kind = K_RBRACK;
              else if (b == ":") e_kind = K_COLON;
              else e_kind = K_COMMA;
            end else if (b == "\"") begin
              mode_next = M_STR; tbeg_next = nxt;
            end else if (is_dig || b == "-") begin
              tbeg_next = pos; nneg_next = (b == "-");
              mant_next = is_dig ? {60'd0, dig} : 64'd0;
              frac_next = '0; expd_next = '0; eneg_next = 1'b0;
              mode_next = is_dig ? M_INT : M_SIGN;
            end else if (b == "t" || b == "f" || b == "n") begin
              mword_next = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
              midx_next = 3'd1; tbeg_next = pos; mode_next = M_LIT;
            end else begin
              emit = 1'b1;
            end
          end
          if (mode != M_IDLE) mode_next = M_IDLE;
        end
      endcase
    end

    // Letters of a failed keyword come out one at a time as undefined tokens.
    if (cmd.held) begin
      emit = 1'b1;
      e_start = tbeg + {{(OFFSET_BITS-3){1'b0}}, hidx};
      hidx_next = hidx + 3'd1;
      if (held_last) begin
        hidx_next = 3'd0; mode_next = M_IDLE;
      end
    end

    if (cmd.close) begin
      unique case (mode)
        M_STR: begin
          emit = 1'b1; e_kind = K_STRING; e_start = tbeg; e_len = nxt - tbeg;
          mode_next = M_IDLE;
        end
        M_INT, M_FRAC, M_EXP, M_SIGN, M_DOT, M_E, M_ESIGN: begin
          emit = 1'b1; e_kind = K_NUMBER; e_num = 1'b1;
          e_ok = (mode == M_INT || mode == M_FRAC || mode == M_EXP);
          e_start = tbeg; e_len = nxt - tbeg; mode_next = M_IDLE;
        end
        default: mode_next = M_IDLE;
      endcase
    end

    if (cmd.end_tok) begin
      emit = 1'b1; e_kind = K_END; e_ok = 1'b1; e_start = nxt; e_len = '0;
      mode_next = M_IDLE; mant_next = '0; frac_next = '0; expd_next = '0;
      eneg_next = 1'b0; nneg_next = 1'b0; pos_next = '0; tbeg_next = '0;
      prev_next = '0; midx_next = '0; mword_next = '0;
    end

    if (cmd.flush && !fin) begin
      pos_next = nxt;
      prev_next = b;
    end
  end

  assign start_ext = {32'd0, e_start};
  assign len_ext = {32'd0, e_len};

  always_comb begin
    new_tok.kind = e_kind;
    new_tok.ok = e_ok;
    new_tok.start = start_ext[31:0];
    new_tok.len = len_ext[31:0];
    new_tok.neg = e_num & nneg;
    new_tok.mant = e_num ? mant : 64'd0;
    new_tok.power = e_num ? pext[15:0] : 16'd0;
    new_tok.last = 1'b0;
  end

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; mant <= '0; frac <= '0; expd <= '0; eneg <= 1'b0;
      nneg <= 1'b0; pos <= '0; tbeg <= '0; prev <= '0; b <= '0; fin <= 1'b0;
      midx <= '0; hidx <= '0; mword <= '0;
    end else begin
      mode <= mode_next; mant <= mant_next; frac <= frac_next; expd <= expd_next;
      eneg <= eneg_next; nneg <= nneg_next; pos <= pos_next; tbeg <= tbeg_next;
      prev <= prev_next; b <= b_next; fin <= fin_next; midx <= midx_next;
      hidx <= hidx_next; mword <= mword_next;
    end
  end

  // A token waits in the hold register until the next one shows whether it
  // is the last transaction of this byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((emit || cmd.flush) && hold_v) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (emit) begin
        if (hold_v) out_tok <= hold;
        hold <= new_tok;
        hold_v <= 1'b1;
      end else if (cmd.flush && hold_v) begin
        out_tok <= {hold[$bits(tok_t)-1:1], 1'b1};
        hold_v <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.can_push = can_push;
    stat.redo = redo;
    stat.lit_miss = lit_miss;
    stat.held_last = held_last;
    stat.is_lit = (mode == M_LIT);
    stat.fin = fin;
    stat.hold_valid = hold_v;
  end

endmodule
